// ----- rtl/pfe_pkg.sv -----
// shared types and constants of the postfix expression evaluator
package pfe_pkg;

	// expression characters
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_CARET = 8'h5e;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_DIVZERO   = 3'd3;
	localparam logic [2:0] ST_BADTOKEN  = 3'd4;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_POW
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_EMIT
	} pfe_state_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_DIV,
		A_POW,
		A_FIN
	} alu_state_t;

	typedef struct packed {
		logic [7:0] token;
		logic       last_token;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} out_word_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} alu_rsp_t;

endpackage

// ----- rtl/pfe_alu.sv -----
// shared iterative arithmetic unit: add, subtract, multiply, divide, power
module pfe_alu import pfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  alu_req_t    req,
	input  logic [31:0] lhs,
	input  logic [31:0] rhs,
	output alu_rsp_t    rsp,
	output logic [31:0] result
);

	localparam logic [5:0] DIV_STEPS = 6'd32;

	alu_state_t  state_q, state_d;
	logic [31:0] w_q;   // accumulator / quotient / result
	logic [31:0] s_q;   // square / partial remainder
	logic [31:0] d_q;   // exponent / divisor magnitude
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        dz_q;

	logic [31:0] mul_a, mul_b, prod, sq_prod;
	logic [32:0] rem_sh, trial;
	logic [31:0] lhs_mag, rhs_mag;

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	// one multiplier shared by product and power accumulate
	always_comb begin
		mul_a = (state_q == A_POW) ? w_q : lhs;
		mul_b = (state_q == A_POW) ? s_q : rhs;
	end

	assign prod    = mul_a * mul_b;
	assign sq_prod = s_q * s_q;
	assign rem_sh  = {s_q, w_q[31]};
	assign trial   = rem_sh - {1'b0, d_q};
	assign lhs_mag = mag(lhs);
	assign rhs_mag = mag(rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					unique case (req.op)
						OP_DIV:  state_d = (rhs == 32'd0) ? A_FIN : A_DIV;
						OP_POW:  state_d = (rhs[31] || rhs == 32'd0) ? A_FIN : A_POW;
						default: state_d = A_FIN;
					endcase
				end
			end
			A_DIV: begin
				if (cnt_q == 6'd1)
					state_d = A_FIN;
			end
			A_POW: begin
				if (d_q[31:1] == 31'd0)
					state_d = A_FIN;
			end
			A_FIN:   state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					neg_q <= 1'b0;
					dz_q  <= 1'b0;
					unique case (req.op)
						OP_ADD: w_q <= lhs + rhs;
						OP_SUB: w_q <= lhs - rhs;
						OP_MUL: w_q <= prod;
						OP_DIV: begin
							s_q   <= 32'd0;
							w_q   <= lhs_mag;
							d_q   <= rhs_mag;
							cnt_q <= DIV_STEPS;
							neg_q <= lhs[31] ^ rhs[31];
							if (rhs == 32'd0) begin
								w_q   <= 32'd0;
								dz_q  <= 1'b1;
								neg_q <= 1'b0;
							end
						end
						OP_POW: begin
							s_q <= lhs;
							d_q <= rhs;
							if (!rhs[31])
								w_q <= 32'd1;
							else if (lhs == 32'd1)
								w_q <= 32'd1;
							else if (lhs == 32'hffff_ffff)
								w_q <= rhs[0] ? 32'hffff_ffff : 32'd1;
							else begin
								// reciprocal truncates to zero, zero base has no reciprocal
								w_q  <= 32'd0;
								dz_q <= (lhs == 32'd0);
							end
						end
						default: w_q <= 32'd0;
					endcase
				end
			end
			A_DIV: begin
				// restoring division, one quotient bit per cycle
				cnt_q <= cnt_q - 6'd1;
				if (!trial[32]) begin
					s_q <= trial[31:0];
					w_q <= {w_q[30:0], 1'b1};
				end else begin
					s_q <= rem_sh[31:0];
					w_q <= {w_q[30:0], 1'b0};
				end
			end
			A_POW: begin
				// square and multiply, exponent bit zero first
				if (d_q[0])
					w_q <= prod;
				s_q <= sq_prod;
				d_q <= {1'b0, d_q[31:1]};
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == A_FIN);
	assign rsp.dz   = dz_q;
	assign result   = neg_q ? (32'd0 - w_q) : w_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == A_IDLE)
		else $error("alu started while busy");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_DIV |-> (cnt_q != 6'd0 && cnt_q <= DIV_STEPS))
		else $error("divide step count out of range");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("done held for more than one cycle");
`endif

endmodule

// ----- rtl/postfix_expression_evaluator_unit.sv -----
// postfix expression evaluator top level: operand stack and token sequencer
//
// token channel (tok_valid / tok_stall / tok): one character per word, with
// last_token marking the end of an expression. digits push 0 to 9, the
// operators + - * / ^ pop two operands and push the result (32-bit wrap,
// division truncates toward zero, power is integer power).
// result channel (res_valid / res_stall / res): one word per expression,
// giving the top of the stack and the first error seen, then the stack and
// status are cleared for the next expression.
// path of each token through the sequencer:
//   digit, bad token, short stack        handled in the idle state
//   + - *, / by zero, ^ exponent <= 0    exec, wait, alu straight to its finish state
//   /                                    exec, wait, 32 restoring steps in the alu
//   ^                                    exec, wait, one exponent bit a cycle in the alu
//   last token then passes the emit state to load the result register
// the divider / power loop in the shared alu sets the worst case.
// tok_stall is high whenever the sequencer is busy with a token.
// the result sits in an output register; while res_stall holds it, new tokens
// are still taken and only the next emission waits for the register to free.
// reset empties the stack, clears the status and drops any pending result.
module postfix_expression_evaluator_unit import pfe_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tok_valid,
	output logic      tok_stall,
	input  in_word_t  tok,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// control state
	pfe_state_t  state_q, state_d;
	logic [DW-1:0] depth_q;
	logic [2:0]  err_q;
	logic        res_valid_q;

	// payload registers
	logic [31:0] tos_q;      // cached top of stack
	logic [31:0] rd_q;       // entry below the top, read from memory
	op_t         op_q;
	logic        last_q;
	out_word_t   res_q;

	// operand stack memory, entries 0 .. depth-1 with the top also in tos_q
	logic [31:0] stk_mem [STACK_DEPTH];

	logic [DW-1:0] below_top;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_we;

	// token decode
	logic        is_digit;
	logic        is_op;
	op_t         dec_op;
	logic [31:0] digit;
	logic        full;

	// sequencer controls
	logic        push;
	logic        wb;
	logic        emit;
	logic        flag_en;
	logic [2:0]  flag_code;

	alu_req_t    alu_req;
	alu_rsp_t    alu_rsp;
	logic [31:0] alu_result;

	assign below_top = depth_q - DW'(2);
	assign rd_addr   = below_top[AW-1:0];
	assign full      = (depth_q >= DW'(STACK_DEPTH));
	assign is_digit  = (tok.token >= CH_0) && (tok.token <= CH_9);
	assign digit     = {24'd0, tok.token - CH_0};

	always_comb begin
		is_op  = 1'b1;
		dec_op = OP_ADD;
		unique case (tok.token)
			CH_PLUS:  dec_op = OP_ADD;
			CH_MINUS: dec_op = OP_SUB;
			CH_STAR:  dec_op = OP_MUL;
			CH_SLASH: dec_op = OP_DIV;
			CH_CARET: dec_op = OP_POW;
			default:  is_op  = 1'b0;
		endcase
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		wb        = 1'b0;
		emit      = 1'b0;
		flag_en   = 1'b0;
		flag_code = ST_OK;
		alu_req   = '{start: 1'b0, op: OP_ADD};
		unique case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					state_d = tok.last_token ? S_EMIT : S_IDLE;
					if (is_digit) begin
						if (full) begin
							// stack full, digit dropped
							flag_en   = 1'b1;
							flag_code = ST_OVERFLOW;
						end else begin
							push = 1'b1;
						end
					end else if (!is_op) begin
						flag_en   = 1'b1;
						flag_code = ST_BADTOKEN;
					end else if (depth_q < DW'(2)) begin
						// too few operands, stack untouched
						flag_en   = 1'b1;
						flag_code = ST_UNDERFLOW;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				// rd_q now holds the left operand
				alu_req.start = 1'b1;
				alu_req.op    = op_q;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (alu_rsp.done) begin
					wb = 1'b1;
					if (alu_rsp.dz) begin
						flag_en   = 1'b1;
						flag_code = ST_DIVZERO;
					end
					state_d = last_q ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				// wait for the output register to be free
				if (!res_valid_q || !res_stall) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// push writes above the top, write-back replaces the left operand
	assign mem_we    = push | wb;
	assign mem_waddr = push ? depth_q[AW-1:0] : rd_addr;
	assign mem_wdata = push ? digit : alu_result;

	always_ff @(posedge clk) begin
		if (mem_we)
			stk_mem[mem_waddr] <= mem_wdata;
		rd_q <= stk_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			err_q       <= ST_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (push)
				depth_q <= depth_q + DW'(1);
			else if (wb)
				depth_q <= depth_q - DW'(1);
			else if (emit)
				depth_q <= '0;

			// first error of an expression is sticky
			if (emit)
				err_q <= ST_OK;
			else if (flag_en && err_q == ST_OK)
				err_q <= flag_code;

			if (emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			tos_q <= digit;
		else if (wb)
			tos_q <= alu_result;

		if (state_q == S_IDLE && tok_valid) begin
			op_q   <= dec_op;
			last_q <= tok.last_token;
		end

		if (emit) begin
			// empty stack gives zero and underflow unless an error is held
			res_q.value  <= (depth_q == '0) ? 32'd0 : tos_q;
			res_q.status <= (depth_q == '0 && err_q == ST_OK) ? ST_UNDERFLOW : err_q;
		end
	end

	pfe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.lhs    (rd_q),
		.rhs    (tos_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	assign tok_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> state_q == S_WAIT)
		else $error("alu result with no operation waiting");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !(res_valid_q && res_stall))
		|=> (depth_q == '0 && err_q == ST_OK && res_valid_q))
		else $error("emission did not clear the stack");
`endif

endmodule
